@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ src/bblc_pkg.sv @@
// types, codes and helpers of the byte budget cache directory
`default_nettype none
package bblc_pkg;
	localparam int KEY_W = 256;
	localparam int SIZE_W = 36;
	localparam int BYTES_W = 40;
	localparam int CNT_W = 48;
	localparam logic [BYTES_W-1:0] DEFAULT_BUDGET = 40'd209715200;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_PEEK = 3'd1,
		ACT_STORE = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_CLEAR = 3'd4,
		ACT_RESET_CNT = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_MISS = 3'd1,
		ST_SMALL = 3'd2,
		ST_REFUSED = 3'd3,
		ST_INVALID = 3'd4,
		ST_EVICT = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_SCAN,
		S_EVAL
	} state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [63:0] key_w0;
		logic [63:0] key_w1;
		logic [63:0] key_w2;
		logic [63:0] key_w3;
		logic [15:0] token_count;
		logic [15:0] embed_width;
		logic [31:0] capacity_values;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] found_tokens;
		logic [15:0] found_width;
		logic evicted;
		logic [63:0] victim_w0;
		logic [63:0] victim_w1;
		logic [63:0] victim_w2;
		logic [63:0] victim_w3;
		logic [BYTES_W-1:0] bytes_in_use;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic write;
		logic set_stamp;
		logic invalidate;
		logic clear_all;
		logic [KEY_W-1:0] key;
		logic [SIZE_W-1:0] size;
		logic [15:0] tokens;
		logic [15:0] width;
		logic [CNT_W-1:0] stamp;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction
endpackage
`default_nettype wire

@@ src/bblc_cell.sv @@
// one directory entry with its key compare and first-match and first-free chains
`default_nettype none
module bblc_cell import bblc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cell_ctl_t ctl,
	input wire logic sel,
	input wire logic [KEY_W-1:0] look_key,
	input wire logic seen_in,
	input wire logic free_in,
	output logic seen_out,
	output logic free_out,
	output logic first_hit,
	output logic first_free,
	output logic valid,
	output logic [KEY_W-1:0] key,
	output logic [SIZE_W-1:0] size,
	output logic [CNT_W-1:0] stamp,
	output logic [15:0] tokens,
	output logic [15:0] width
);
	logic valid_q;
	logic [KEY_W-1:0] key_q;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0] stamp_q;
	logic [15:0] tokens_q;
	logic [15:0] width_q;
	logic match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear_all) begin
			valid_q <= 1'b0;
		end else if (sel && ctl.write) begin
			valid_q <= 1'b1;
		end else if (sel && ctl.invalidate) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctl.write) begin
			key_q <= ctl.key;
			size_q <= ctl.size;
			tokens_q <= ctl.tokens;
			width_q <= ctl.width;
		end
		if (sel && (ctl.write || ctl.set_stamp)) begin
			stamp_q <= ctl.stamp;
		end
	end

	assign match = valid_q && (key_q == look_key);
	assign first_hit = match && !seen_in;
	assign seen_out = seen_in || match;
	assign first_free = !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign valid = valid_q;
	assign key = key_q;
	assign size = size_q;
	assign stamp = stamp_q;
	assign tokens = tokens_q;
	assign width = width_q;
endmodule
`default_nettype wire

@@ src/byte_budget_lru_cache_directory.sv @@
// top level of the byte budget lru cache directory
// A request transfer is taken only while the block is idle. Lookup, peek, remove,
// clear and counter reset pass through key match through the cell chain, decode and
// result. A store that is valid and within the budget adds scans of the cells for the
// oldest stamp: one scan to place the item and one more per evicted entry, each
// victim leaving as its own result transfer. Results wait in an output register, and a
// stalled result transfer holds the block. Writing budget 0 selects 200 MiB.
`default_nettype none
module byte_budget_lru_cache_directory import bblc_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int HEADER_BYTES = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [BYTES_W-1:0] cfg_data
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t state_q, state_d;
	req_t req_q;
	logic [BYTES_W-1:0] budget_q;
	logic [BYTES_W-1:0] bt_q, bt_d;
	logic [CNT_W-1:0] hit_q, hit_d, miss_q, miss_d, clock_q, clock_d;
	logic found_q;
	logic [IW-1:0] slot_q;
	logic [31:0] prod_q;
	logic [SIZE_W-1:0] need_q;
	logic [IW-1:0] scan_q, scan_d;
	logic any_q, any_d;
	logic [IW-1:0] old_q, old_d;
	logic [CNT_W-1:0] old_stamp_q, old_stamp_d;
	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q, emit;
	logic out_free, accept;

	cell_ctl_t ctl;
	logic [IW-1:0] cell_idx;
	logic [ENTRIES:0] seen_ch, free_ch;
	logic [ENTRIES-1:0] c_hit, c_free, c_valid;
	logic [KEY_W-1:0] c_key [ENTRIES];
	logic [SIZE_W-1:0] c_size [ENTRIES];
	logic [CNT_W-1:0] c_stamp [ENTRIES];
	logic [15:0] c_tok [ENTRIES];
	logic [15:0] c_wid [ENTRIES];
	logic [KEY_W-1:0] look_key;
	logic [IW-1:0] hit_idx, free_idx;
	logic fits;

	assign look_key = {req_q.key_w3, req_q.key_w2, req_q.key_w1, req_q.key_w0};
	assign seen_ch[0] = 1'b0;
	assign free_ch[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bblc_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .sel(cell_idx == IW'(g)),
			.look_key(look_key), .seen_in(seen_ch[g]), .free_in(free_ch[g]),
			.seen_out(seen_ch[g+1]), .free_out(free_ch[g+1]),
			.first_hit(c_hit[g]), .first_free(c_free[g]), .valid(c_valid[g]),
			.key(c_key[g]), .size(c_size[g]), .stamp(c_stamp[g]),
			.tokens(c_tok[g]), .width(c_wid[g])
		);
	end

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (c_hit[i]) hit_idx = hit_idx | IW'(i);
			if (c_free[i]) free_idx = free_idx | IW'(i);
		end
	end

	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fits = ({1'b0, bt_q} + {5'd0, need_q}) <= {1'b0, budget_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_d = S_MATCH;
			S_MATCH: state_d = S_DECIDE;
			S_DECIDE: begin
				if (out_free) begin
					if (req_q.action == ACT_STORE && req_q.token_count != '0 &&
					    req_q.embed_width != '0 && {4'd0, need_q} <= budget_q)
						state_d = S_SCAN;
					else
						state_d = S_IDLE;
				end
			end
			S_SCAN: if (scan_q == IW'(ENTRIES - 1)) state_d = S_EVAL;
			S_EVAL: begin
				if (out_free) begin
					if (!any_q || (fits && free_ch[ENTRIES])) state_d = S_IDLE;
					else state_d = S_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.key = look_key;
		ctl.size = need_q;
		ctl.tokens = req_q.token_count;
		ctl.width = req_q.embed_width;
		ctl.stamp = sat_inc(clock_q);
		cell_idx = slot_q;
		bt_d = bt_q;
		hit_d = hit_q;
		miss_d = miss_q;
		clock_d = clock_q;
		scan_d = scan_q;
		any_d = any_q;
		old_d = old_q;
		old_stamp_d = old_stamp_q;
		emit = 1'b0;
		rsp_d = '0;
		rsp_d.last = 1'b1;
		unique case (state_q)
			S_DECIDE: begin
				if (out_free) begin
					emit = 1'b1;
					scan_d = '0;
					any_d = 1'b0;
					unique case (req_q.action)
						ACT_LOOKUP: begin
							if (!found_q) begin
								miss_d = sat_inc(miss_q);
								rsp_d.status = ST_MISS;
							end else if (prod_q > req_q.capacity_values) begin
								miss_d = sat_inc(miss_q);
								rsp_d.status = ST_SMALL;
							end else begin
								ctl.set_stamp = 1'b1;
								clock_d = sat_inc(clock_q);
								hit_d = sat_inc(hit_q);
								rsp_d.status = ST_OK;
								rsp_d.found_tokens = c_tok[slot_q];
								rsp_d.found_width = c_wid[slot_q];
							end
						end
						ACT_PEEK: begin
							rsp_d.status = found_q ? ST_OK : ST_MISS;
							if (found_q) begin
								rsp_d.found_tokens = c_tok[slot_q];
								rsp_d.found_width = c_wid[slot_q];
							end
						end
						ACT_STORE: begin
							if (req_q.token_count == '0 || req_q.embed_width == '0) begin
								rsp_d.status = ST_INVALID;
							end else begin
								if (found_q) begin
									ctl.invalidate = 1'b1;
									bt_d = bt_q - {4'd0, c_size[slot_q]};
								end
								if ({4'd0, need_q} > budget_q) rsp_d.status = ST_REFUSED;
								else emit = 1'b0;
							end
						end
						ACT_REMOVE: begin
							if (found_q) begin
								ctl.invalidate = 1'b1;
								bt_d = bt_q - {4'd0, c_size[slot_q]};
								rsp_d.status = ST_OK;
							end else begin
								rsp_d.status = ST_MISS;
							end
						end
						ACT_CLEAR: begin
							ctl.clear_all = 1'b1;
							bt_d = '0;
							hit_d = '0;
							miss_d = '0;
							rsp_d.status = ST_OK;
						end
						ACT_RESET_CNT: begin
							hit_d = '0;
							miss_d = '0;
							rsp_d.status = ST_OK;
						end
						default: rsp_d.status = ST_INVALID;
					endcase
				end
			end
			S_SCAN: begin
				if (c_valid[scan_q] && (!any_q || c_stamp[scan_q] < old_stamp_q)) begin
					any_d = 1'b1;
					old_d = scan_q;
					old_stamp_d = c_stamp[scan_q];
				end
				scan_d = scan_q + 1'b1;
			end
			S_EVAL: begin
				if (out_free) begin
					emit = 1'b1;
					scan_d = '0;
					any_d = 1'b0;
					if (!any_q || (fits && free_ch[ENTRIES])) begin
						cell_idx = free_ch[ENTRIES] ? free_idx : '0;
						ctl.write = 1'b1;
						clock_d = sat_inc(clock_q);
						bt_d = BYTES_W'({1'b0, bt_q} + {5'd0, need_q});
						rsp_d.status = ST_OK;
					end else begin
						cell_idx = old_q;
						ctl.invalidate = 1'b1;
						bt_d = bt_q - {4'd0, c_size[old_q]};
						rsp_d.status = ST_EVICT;
						rsp_d.evicted = 1'b1;
						rsp_d.victim_w0 = c_key[old_q][63:0];
						rsp_d.victim_w1 = c_key[old_q][127:64];
						rsp_d.victim_w2 = c_key[old_q][191:128];
						rsp_d.victim_w3 = c_key[old_q][255:192];
						rsp_d.last = 1'b0;
					end
				end
			end
			default: ;
		endcase
		rsp_d.bytes_in_use = bt_d;
		rsp_d.hit_total = hit_d;
		rsp_d.miss_total = miss_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			budget_q <= DEFAULT_BUDGET;
			bt_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			clock_q <= '0;
			rsp_valid_q <= 1'b0;
			scan_q <= '0;
			any_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) budget_q <= (cfg_data == '0) ? DEFAULT_BUDGET : cfg_data;
			bt_q <= bt_d;
			hit_q <= hit_d;
			miss_q <= miss_d;
			clock_q <= clock_d;
			scan_q <= scan_d;
			any_q <= any_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (state_q == S_MATCH) begin
			found_q <= seen_ch[ENTRIES];
			slot_q <= hit_idx;
			prod_q <= c_tok[hit_idx] * c_wid[hit_idx];
			need_q <= SIZE_W'(HEADER_BYTES) +
				{32'(req_q.token_count) * 32'(req_q.embed_width), 2'b00};
		end
		old_q <= old_d;
		old_stamp_q <= old_stamp_d;
		if (emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire

@@ src/bblc_checker.sv @@
// port checker of the byte budget cache directory and its bind
`default_nettype none
`include "assert_macros.svh"
module bblc_checker import bblc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
	`ASSERT_IMP(a_evict_code, clk, arst_n, rsp_valid && rsp.evicted, rsp.status == ST_EVICT)
	`ASSERT_IMP(a_evict_not_last, clk, arst_n, rsp_valid && rsp.evicted, !rsp.last)
	`ASSERT_CLK(a_busy_after_take, clk, arst_n, req_valid && !req_stall |=> req_stall)
endmodule

bind byte_budget_lru_cache_directory bblc_checker u_bblc_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
`default_nettype wire

@@ test/byte_budget_lru_cache_directory_tb.sv @@
// testbench of the byte budget lru cache directory: directed and random requests checked against a predictor
`default_nettype none
module byte_budget_lru_cache_directory_tb import bblc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENT = 32;
	localparam int HDR = 24;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [BYTES_W-1:0] cfg_data = '0;

	byte_budget_lru_cache_directory #(.ENTRIES(N_ENT), .HEADER_BYTES(HDR)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [BYTES_W-1:0] budget;
	logic slot_used [N_ENT];
	logic [255:0] slot_key [N_ENT];
	logic [SIZE_W-1:0] slot_size [N_ENT];
	logic [CNT_W-1:0] slot_stamp [N_ENT];
	logic [15:0] slot_tok [N_ENT];
	logic [15:0] slot_wid [N_ENT];
	logic [BYTES_W-1:0] pred_bytes;
	logic [CNT_W-1:0] hits, misses, use_clk;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int mismatches = 0;
	int unexpected = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	longint unsigned cycles = 0;

	// key pool so that stores, lookups and removes hit each other
	logic [255:0] key_pool [12];

	function automatic rsp_t make_rsp(logic [2:0] st, logic [15:0] t, logic [15:0] w,
			int victim, logic lst);
		rsp_t r;
		r.status = st;
		r.found_tokens = t;
		r.found_width = w;
		r.evicted = (victim >= 0);
		{r.victim_w3, r.victim_w2, r.victim_w1, r.victim_w0} =
			(victim >= 0) ? slot_key[victim] : 256'd0;
		r.bytes_in_use = pred_bytes;
		r.hit_total = hits;
		r.miss_total = misses;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_cache(input req_t q);
		logic [255:0] k;
		int slot, oldest, free_slot;
		logic any;
		logic [63:0] need;
		logic [63:0] prod;
		k = {q.key_w3, q.key_w2, q.key_w1, q.key_w0};
		slot = -1;
		for (int i = N_ENT - 1; i >= 0; i--)
			if (slot_used[i] && slot_key[i] == k) slot = i;
		case (q.action)
			ACT_LOOKUP: begin
				if (slot < 0) begin
					misses = sat_inc(misses);
					expected_rsps.push_back(make_rsp(ST_MISS, 16'd0, 16'd0, -1, 1'b1));
				end else begin
					prod = 64'(slot_tok[slot]) * 64'(slot_wid[slot]);
					if (prod > 64'(q.capacity_values)) begin
						misses = sat_inc(misses);
						expected_rsps.push_back(make_rsp(ST_SMALL, 16'd0, 16'd0, -1, 1'b1));
					end else begin
						use_clk = sat_inc(use_clk);
						slot_stamp[slot] = use_clk;
						hits = sat_inc(hits);
						expected_rsps.push_back(make_rsp(ST_OK, slot_tok[slot],
							slot_wid[slot], -1, 1'b1));
					end
				end
			end
			ACT_PEEK: begin
				if (slot < 0)
					expected_rsps.push_back(make_rsp(ST_MISS, 16'd0, 16'd0, -1, 1'b1));
				else expected_rsps.push_back(make_rsp(ST_OK, slot_tok[slot],
					slot_wid[slot], -1, 1'b1));
			end
			ACT_STORE: begin
				if (q.token_count == 0 || q.embed_width == 0) begin
					expected_rsps.push_back(make_rsp(ST_INVALID, 16'd0, 16'd0, -1, 1'b1));
				end else begin
					need = 64'(HDR) + 64'(q.token_count) * 64'(q.embed_width) * 64'd4;
					if (slot >= 0) begin
						pred_bytes = pred_bytes - BYTES_W'(slot_size[slot]);
						slot_used[slot] = 1'b0;
					end
					if (need > 64'(budget)) begin
						expected_rsps.push_back(make_rsp(ST_REFUSED, 16'd0, 16'd0, -1, 1'b1));
					end else begin
						forever begin
							any = 1'b0;
							oldest = -1;
							free_slot = -1;
							for (int i = 0; i < N_ENT; i++) begin
								if (slot_used[i]) begin
									any = 1'b1;
									if (oldest < 0 || slot_stamp[i] < slot_stamp[oldest])
										oldest = i;
								end else if (free_slot < 0) free_slot = i;
							end
							if (!any || (64'(pred_bytes) + need <= 64'(budget)
									&& free_slot >= 0))
								break;
							pred_bytes = pred_bytes - BYTES_W'(slot_size[oldest]);
							slot_used[oldest] = 1'b0;
							expected_rsps.push_back(make_rsp(ST_EVICT, 16'd0, 16'd0, oldest,
								1'b0));
						end
						if (free_slot < 0) free_slot = 0;
						slot_used[free_slot] = 1'b1;
						slot_key[free_slot] = k;
						slot_size[free_slot] = SIZE_W'(need);
						slot_tok[free_slot] = q.token_count;
						slot_wid[free_slot] = q.embed_width;
						use_clk = sat_inc(use_clk);
						slot_stamp[free_slot] = use_clk;
						pred_bytes = pred_bytes + BYTES_W'(need);
						expected_rsps.push_back(make_rsp(ST_OK, 16'd0, 16'd0, -1, 1'b1));
					end
				end
			end
			ACT_REMOVE: begin
				if (slot < 0)
					expected_rsps.push_back(make_rsp(ST_MISS, 16'd0, 16'd0, -1, 1'b1));
				else begin
					pred_bytes = pred_bytes - BYTES_W'(slot_size[slot]);
					slot_used[slot] = 1'b0;
					expected_rsps.push_back(make_rsp(ST_OK, 16'd0, 16'd0, -1, 1'b1));
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < N_ENT; i++) slot_used[i] = 1'b0;
				pred_bytes = '0;
				hits = '0;
				misses = '0;
				expected_rsps.push_back(make_rsp(ST_OK, 16'd0, 16'd0, -1, 1'b1));
			end
			ACT_RESET_CNT: begin
				hits = '0;
				misses = '0;
				expected_rsps.push_back(make_rsp(ST_OK, 16'd0, 16'd0, -1, 1'b1));
			end
			default: expected_rsps.push_back(make_rsp(ST_INVALID, 16'd0, 16'd0, -1, 1'b1));
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (req_valid && !req_stall) begin
			predict_cache(req);
		end
		if (!req_valid || !req_stall) begin
			if (pending_reqs.size() != 0 && arst_n && !cfg_we
					&& $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_reqs.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				unexpected++;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer %p", rsp);
			end else begin
				exp_r = expected_rsps.pop_front();
				if (rsp !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("** byte_budget_lru_cache_directory: FAILED **");
			$finish;
		end
	end

	function automatic req_t rand_req(int act);
		req_t q;
		int r;
		q.action = 3'(act);
		{q.key_w3, q.key_w2, q.key_w1, q.key_w0} =
			($urandom_range(9) == 0)
			? {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom}
			: key_pool[$urandom_range(11)];
		r = $urandom_range(19);
		if (r == 0) q.token_count = 16'hFFFF;
		else if (r == 1) q.token_count = 16'(0);
		else if (r == 2) q.token_count = 16'($urandom);
		else q.token_count = 16'($urandom_range(1, 300));
		r = $urandom_range(19);
		if (r == 0) q.embed_width = 16'hFFFF;
		else if (r == 1) q.embed_width = 16'(0);
		else if (r == 2) q.embed_width = 16'($urandom);
		else q.embed_width = 16'($urandom_range(1, 64));
		r = $urandom_range(7);
		if (r == 0) q.capacity_values = 32'hFFFF_FFFF;
		else if (r == 1) q.capacity_values = 32'($urandom);
		else q.capacity_values = 32'($urandom_range(0, 20000));
		return q;
	endfunction

	// sampled away from the rising edge so that the driver's updates have settled
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || req_stall
				|| expected_rsps.size() != 0)
			@(negedge clk);
		repeat (3 * N_ENT + 20) @(posedge clk);
	endtask

	task automatic write_budget(input logic [BYTES_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		budget = (v == 0) ? DEFAULT_BUDGET : v;
		@(posedge clk);
	endtask

	initial begin
		req_t q;
		int act;
		budget = DEFAULT_BUDGET;
		for (int i = 0; i < N_ENT; i++) slot_used[i] = 1'b0;
		pred_bytes = '0;
		hits = '0;
		misses = '0;
		use_clk = '0;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		q = rand_req(ACT_LOOKUP); q.key_w0 = '0; q.key_w1 = '0; q.key_w2 = '0; q.key_w3 = '0;
		pending_reqs.push_back(q);
		q.action = ACT_STORE; q.token_count = 16'hFFFF; q.embed_width = 16'hFFFF;
		pending_reqs.push_back(q);
		q.token_count = 16'd0; q.embed_width = 16'd5; pending_reqs.push_back(q);
		q.token_count = 16'd5; q.embed_width = 16'd0; pending_reqs.push_back(q);
		q.token_count = 16'd10; q.embed_width = 16'd8; pending_reqs.push_back(q);
		q.action = ACT_LOOKUP; q.capacity_values = 32'd79; pending_reqs.push_back(q);
		q.capacity_values = 32'd80; pending_reqs.push_back(q);
		q.capacity_values = 32'hFFFF_FFFF; pending_reqs.push_back(q);
		q.action = ACT_PEEK; pending_reqs.push_back(q);
		{q.key_w3, q.key_w2, q.key_w1, q.key_w0} = '1;
		q.action = ACT_PEEK; pending_reqs.push_back(q);
		q.action = ACT_STORE; q.token_count = 16'd100; q.embed_width = 16'd100;
		pending_reqs.push_back(q);
		q.action = ACT_STORE; q.token_count = 16'd3; pending_reqs.push_back(q);
		q.action = ACT_REMOVE; pending_reqs.push_back(q);
		pending_reqs.push_back(q);
		q.action = ACT_RESET_CNT; pending_reqs.push_back(q);
		q.action = 3'd6; pending_reqs.push_back(q);
		q.action = 3'd7; pending_reqs.push_back(q);
		q.action = ACT_CLEAR; pending_reqs.push_back(q);
		wait_drained();

		// tiny budget forces evictions
		write_budget(40'd2000);
		for (int i = 0; i < 8; i++) begin
			q = rand_req(ACT_STORE);
			q.token_count = 16'($urandom_range(1, 6)); q.embed_width = 16'($urandom_range(1, 20));
			pending_reqs.push_back(q);
		end
		wait_drained();
		write_budget(40'hFF_FFFF_FFFF);
		// fill past the table size
		for (int i = 0; i < N_ENT + 4; i++) begin
			q = rand_req(ACT_STORE);
			{q.key_w3, q.key_w2, q.key_w1, q.key_w0} =
				{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			q.token_count = 16'($urandom_range(1, 9)); q.embed_width = 16'($urandom_range(1, 9));
			pending_reqs.push_back(q);
		end
		q.action = ACT_CLEAR; pending_reqs.push_back(q);
		wait_drained();

		// random phases with varying budget, idling and result stalls
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; write_budget(40'd0); end
				1: begin send_idle_pct = 47; stall_pct = 0; write_budget(40'd1); end
				2: begin send_idle_pct = 0; stall_pct = 47; write_budget(40'd30000); end
				default: begin send_idle_pct = 35; stall_pct = 35; write_budget(40'd6000); end
			endcase
			for (int i = 0; i < 25; i++) begin
				act = $urandom_range(99);
				if (act < 40) act = ACT_STORE;
				else if (act < 65) act = ACT_LOOKUP;
				else if (act < 78) act = ACT_PEEK;
				else if (act < 90) act = ACT_REMOVE;
				else if (act < 94) act = ACT_RESET_CNT;
				else if (act < 96) act = ACT_CLEAR;
				else act = $urandom_range(6, 7);
				pending_reqs.push_back(rand_req(act));
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("** byte_budget_lru_cache_directory: PASSED **");
		else
			$display("** byte_budget_lru_cache_directory: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
